// File: rtl/lpce_pkg.sv
// Package for the lidar packet compact encoder.
// Types, codes and fixed constants shared by the front, queue, back and top level.
// No dependencies.
package lpce_pkg;

	localparam int CHANNELS     = 16;
	localparam int BLOCK_BYTES  = 100;
	localparam int BLOCK_COUNT  = 12;
	localparam int TAIL_BYTES   = 6;
	localparam int AZ_W         = 18;
	localparam logic [AZ_W-1:0] AZ_FULL  = 18'd72000;
	localparam logic [AZ_W-1:0] AZ_LIMIT = 18'd131071;
	localparam logic [15:0] DIV5_MUL = 16'd52429;
	localparam int DIV5_SHIFT = 18;
	localparam int QUEUE_DEPTH = 4;

	// configuration register indexes
	localparam logic [2:0] REG_OUTPUT_MODE   = 3'd0;
	localparam logic [2:0] REG_CM_UNITS      = 3'd1;
	localparam logic [2:0] REG_INT_BITS      = 3'd2;
	localparam logic [2:0] REG_INT_LOW       = 3'd3;
	localparam logic [2:0] REG_SENSOR_ORDER  = 3'd4;

	// output_mode codes
	localparam logic [1:0] MODE_PLAIN  = 2'd0;
	localparam logic [1:0] MODE_PACKED = 2'd1;
	localparam logic [1:0] MODE_BOTH   = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	// result kind codes
	localparam logic [1:0] KIND_PLAIN     = 2'd0;
	localparam logic [1:0] KIND_PACKED    = 2'd1;
	localparam logic [1:0] KIND_FRAME_END = 2'd2;

	typedef logic [CHANNELS-1:0][15:0] group_t;

	typedef struct packed {
		logic [1:0] output_mode;
		logic       centimetre_units;
		logic [3:0] intensity_bits;
		logic       intensity_low_placement;
	} front_cfg_t;

	typedef enum logic {
		CMD_FRAME_END,
		CMD_GROUP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic        plain_en;
		logic        packed_en;
		logic [16:0] start_az;
		logic [16:0] end_az;
		logic        last;
	} cmd_t;

	typedef enum logic [3:0] {
		F_IDLE,
		F_DIV,
		F_STORE,
		F_NEXT,
		F_HALF,
		F_MID,
		F_WRAP,
		F_GRP,
		F_CUR,
		F_CMP
	} front_state_t;

endpackage

// File: rtl/lpce_queue.sv
// Command queue between the packet front end and the word back end.
// Small flop FIFO of lpce_pkg::cmd_t entries.
// Depends on lpce_pkg.
module lpce_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lpce_pkg::cmd_t push_cmd,
	input  logic           pop,
	output lpce_pkg::cmd_t head,
	output logic           full,
	output logic           empty
);
	localparam int AW = $clog2(lpce_pkg::QUEUE_DEPTH);

	lpce_pkg::cmd_t mem_q [lpce_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	assign full  = (cnt_q == (AW+1)'(lpce_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/lpce_front.sv
// Packet front end: parses payload bytes, tracks azimuths and point count,
// builds return groups and issues frame-end and group commands.
// Depends on lpce_pkg.
module lpce_front #(
	parameter int MAX_POINTS = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                packet_start,
	input  lpce_pkg::front_cfg_t cfg,
	input  logic                q_full,
	output logic                q_push,
	output lpce_pkg::cmd_t      q_cmd,
	input  logic                snap_busy,
	output logic                snap_load,
	output lpce_pkg::group_t    plain_grp,
	output lpce_pkg::group_t    packed_grp
);
	localparam int PCW = $clog2(MAX_POINTS + 1);
	localparam logic [PCW:0] MAX_EXT = (PCW+1)'(MAX_POINTS);
	localparam int AW = lpce_pkg::AZ_W;

	lpce_pkg::front_state_t state_q, state_d;

	logic [3:0]  blk_q;
	logic [6:0]  off_q;
	logic [4:0]  r_q;
	logic [1:0]  k_q;
	logic [15:0] hold_q;
	logic [AW-1:0] cur_q, nxt_q, half_q, az_q;
	logic [16:0] prev_q, start_q;
	logic [PCW-1:0] pc_q;
	logic        pend_q;
	logic        az_path_q;
	logic [15:0] raw_q;
	logic [7:0]  inten_q;
	logic [3:0]  sid_q;
	logic [15:0] d_s1;
	lpce_pkg::front_state_t after_q;
	lpce_pkg::group_t plain_q, packed_q;
	lpce_pkg::cmd_t held_q;
	logic        held_v_q;

	// byte position as seen by an accepted word
	logic [3:0] b_eff;
	logic [6:0] o_eff;
	logic [4:0] r_eff;
	logic [1:0] k_eff;
	logic       pend_eff;
	logic       accept;
	logic       pc_full;
	logic       grp_fits;
	logic       grp_emit;
	logic       can_push;
	logic       push_new;
	lpce_pkg::cmd_t new_cmd;
	logic       step;
	logic [AW-1:0] wrap_az;
	logic [AW-1:0] cur_adj;
	logic [AW:0] half_diff;
	logic [AW:0] half_rnd;
	logic [AW:0] mid_sum;
	logic [31:0] prod;
	logic [15:0] pack_w;
	logic [3:0]  n_bits;
	logic [15:0] hi_mask;
	logic [15:0] lo_mask;
	logic [7:0]  inten_top;
	logic [31:0] top_shift;
	logic [15:0] d_in;

	assign b_eff    = packet_start ? 4'd0 : blk_q;
	assign o_eff    = packet_start ? 7'd0 : off_q;
	assign r_eff    = packet_start ? 5'd0 : r_q;
	assign k_eff    = packet_start ? 2'd0 : k_q;
	assign pend_eff = packet_start ? 1'b0 : pend_q;

	assign in_stall = (state_q != lpce_pkg::F_IDLE) || held_v_q;
	assign accept   = in_valid && !in_stall;
	assign can_push = !held_v_q || !q_full;

	assign pc_full  = ({1'b0, pc_q} >= MAX_EXT);
	assign grp_fits = ({1'b0, pc_q} + (PCW+1)'(lpce_pkg::CHANNELS) <= MAX_EXT);
	assign grp_emit = (cfg.output_mode != lpce_pkg::MODE_NONE) && !pc_full && grp_fits;

	assign plain_grp  = plain_q;
	assign packed_grp = packed_q;

	// wrap of the mid-block azimuth, clamped to the 17-bit range
	always_comb begin
		wrap_az = cur_q - lpce_pkg::AZ_FULL;
		if (wrap_az > lpce_pkg::AZ_LIMIT) begin
			wrap_az = lpce_pkg::AZ_LIMIT;
		end
	end
	assign cur_adj = (nxt_q > lpce_pkg::AZ_FULL) ? nxt_q - lpce_pkg::AZ_FULL : nxt_q;

	// signed half step, rounded toward zero; half_q holds it in two's complement
	assign half_diff = {1'b0, nxt_q} - {1'b0, cur_q};
	assign half_rnd  = half_diff + {{AW{1'b0}}, half_diff[AW]};
	assign mid_sum   = {1'b0, cur_q} + {half_q[AW-1], half_q};

	// divide by five through the reciprocal
	assign prod = {16'd0, raw_q} * {16'd0, lpce_pkg::DIV5_MUL};

	// intensity packing
	always_comb begin
		d_in      = d_s1;
		n_bits    = (cfg.intensity_bits > 4'd8) ? 4'd8 : cfg.intensity_bits;
		inten_top = inten_q >> (4'd8 - n_bits);
		top_shift = {24'd0, inten_top} << (5'd16 - {1'b0, n_bits});
		hi_mask   = 16'hFFFF >> n_bits;
		lo_mask   = 16'hFFFF << n_bits;
		if (n_bits == 4'd0) begin
			pack_w = '0;
		end else if (!cfg.intensity_low_placement) begin
			pack_w = (d_in <= hi_mask) ? (top_shift[15:0] | d_in) : 16'd0;
		end else begin
			pack_w = (d_in & lo_mask) | {8'd0, inten_top};
		end
	end

	always_comb begin
		state_d  = state_q;
		step     = 1'b0;
		push_new = 1'b0;
		new_cmd  = '0;
		new_cmd.kind     = lpce_pkg::CMD_FRAME_END;
		new_cmd.start_az = start_q;
		new_cmd.end_az   = prev_q;
		snap_load = 1'b0;
		case (state_q)
			lpce_pkg::F_IDLE: begin
				if (accept) begin
					step = 1'b1;
					if (b_eff != 4'(lpce_pkg::BLOCK_COUNT) && o_eff == 7'd3) begin
						if (b_eff == 4'd0) begin
							state_d = lpce_pkg::F_CMP;
						end else if (pend_eff && !pc_full) begin
							state_d = lpce_pkg::F_NEXT;
						end else begin
							state_d = lpce_pkg::F_CUR;
						end
					end else if (b_eff != 4'(lpce_pkg::BLOCK_COUNT) && o_eff >= 7'd4
							&& k_eff == 2'd2) begin
						state_d = lpce_pkg::F_DIV;
					end
				end
			end
			lpce_pkg::F_DIV: begin
				step    = 1'b1;
				state_d = lpce_pkg::F_STORE;
			end
			lpce_pkg::F_STORE: begin
				step    = 1'b1;
				state_d = after_q;
			end
			lpce_pkg::F_NEXT: begin
				step    = 1'b1;
				state_d = lpce_pkg::F_HALF;
			end
			lpce_pkg::F_HALF: begin
				step    = 1'b1;
				state_d = lpce_pkg::F_MID;
			end
			lpce_pkg::F_MID: begin
				step    = 1'b1;
				state_d = lpce_pkg::F_WRAP;
			end
			lpce_pkg::F_WRAP: begin
				if (cur_q > lpce_pkg::AZ_FULL) begin
					if (can_push) begin
						step     = 1'b1;
						push_new = 1'b1;
						state_d  = lpce_pkg::F_GRP;
					end
				end else begin
					step    = 1'b1;
					state_d = lpce_pkg::F_GRP;
				end
			end
			lpce_pkg::F_GRP: begin
				if (grp_emit) begin
					if (can_push && !snap_busy) begin
						step      = 1'b1;
						push_new  = 1'b1;
						snap_load = 1'b1;
						new_cmd.kind      = lpce_pkg::CMD_GROUP;
						new_cmd.plain_en  = (cfg.output_mode == lpce_pkg::MODE_PLAIN)
							|| (cfg.output_mode == lpce_pkg::MODE_BOTH);
						new_cmd.packed_en = (cfg.output_mode == lpce_pkg::MODE_PACKED)
							|| (cfg.output_mode == lpce_pkg::MODE_BOTH);
						new_cmd.start_az  = '0;
						new_cmd.end_az    = '0;
					end
				end else begin
					step = 1'b1;
				end
				if (step) begin
					state_d = az_path_q ? lpce_pkg::F_CUR : lpce_pkg::F_IDLE;
				end
			end
			lpce_pkg::F_CUR: begin
				step    = 1'b1;
				state_d = lpce_pkg::F_CMP;
			end
			lpce_pkg::F_CMP: begin
				if (cur_q[16:0] < prev_q) begin
					if (can_push) begin
						step     = 1'b1;
						push_new = 1'b1;
						state_d  = lpce_pkg::F_IDLE;
					end
				end else begin
					step    = 1'b1;
					state_d = lpce_pkg::F_IDLE;
				end
			end
			default: begin
				state_d = lpce_pkg::F_IDLE;
			end
		endcase

		// push the held command; it is marked last only when flushed from idle
		q_push = 1'b0;
		q_cmd  = held_q;
		if (push_new && held_v_q) begin
			q_push     = 1'b1;
			q_cmd.last = 1'b0;
		end else if (state_q == lpce_pkg::F_IDLE && held_v_q && !q_full) begin
			q_push     = 1'b1;
			q_cmd.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpce_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// data path without reset
	always_ff @(posedge clk) begin
		if (step) begin
			case (state_q)
				lpce_pkg::F_IDLE: begin
					if (o_eff == 7'd3) begin
						az_q <= {1'b0, data_byte, hold_q[7:0], 1'b0};
					end
					if (o_eff >= 7'd4 && k_eff == 2'd2) begin
						raw_q   <= hold_q;
						inten_q <= data_byte;
						sid_q   <= r_eff[3:0];
					end
				end
				lpce_pkg::F_DIV: begin
					d_s1 <= cfg.centimetre_units ? raw_q
						: {2'd0, prod[lpce_pkg::DIV5_SHIFT +: 14]};
				end
				lpce_pkg::F_STORE: begin
					plain_q[sid_q]  <= d_s1;
					packed_q[sid_q] <= pack_w;
				end
				lpce_pkg::F_HALF: begin
					half_q <= half_rnd[AW:1];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q     <= '0;
			off_q     <= '0;
			r_q       <= '0;
			k_q       <= '0;
			hold_q    <= '0;
			cur_q     <= '0;
			nxt_q     <= '0;
			prev_q    <= '0;
			start_q   <= '0;
			pc_q      <= '0;
			pend_q    <= 1'b0;
			az_path_q <= 1'b0;
			after_q   <= lpce_pkg::F_IDLE;
			held_q    <= '0;
			held_v_q  <= 1'b0;
		end else begin
			if (push_new) begin
				held_q   <= new_cmd;
				held_v_q <= 1'b1;
			end else if (q_push) begin
				held_v_q <= 1'b0;
			end
			if (step) begin
				case (state_q)
					lpce_pkg::F_IDLE: begin
						if (packet_start) begin
							pend_q <= 1'b0;
						end
						if (b_eff == 4'(lpce_pkg::BLOCK_COUNT)) begin
							// drop trailer bytes and anything past the packet
							blk_q <= b_eff;
							off_q <= (o_eff < 7'(lpce_pkg::TAIL_BYTES)) ? o_eff + 7'd1 : o_eff;
						end else begin
							if (o_eff == 7'(lpce_pkg::BLOCK_BYTES - 1)) begin
								off_q <= '0;
								blk_q <= b_eff + 4'd1;
								r_q   <= '0;
								k_q   <= '0;
							end else begin
								off_q <= o_eff + 7'd1;
								blk_q <= b_eff;
								if (o_eff >= 7'd4) begin
									k_q <= (k_eff == 2'd2) ? 2'd0 : k_eff + 2'd1;
									r_q <= (k_eff == 2'd2) ? r_eff + 5'd1 : r_eff;
								end else begin
									k_q <= k_eff;
									r_q <= r_eff;
								end
							end
							if (o_eff == 7'd2) begin
								hold_q <= {8'd0, data_byte};
							end else if (o_eff == 7'd3) begin
								az_path_q <= 1'b1;
								if (b_eff == 4'd0) begin
									cur_q <= {1'b0, data_byte, hold_q[7:0], 1'b0};
								end else if (pend_eff) begin
									pend_q <= 1'b0;
								end
							end else if (o_eff >= 7'd4) begin
								case (k_eff)
									2'd0:    hold_q <= {8'd0, data_byte};
									2'd1:    hold_q <= {data_byte, hold_q[7:0]};
									default: begin
										az_path_q <= 1'b0;
										if (r_eff == 5'd15) begin
											after_q <= lpce_pkg::F_GRP;
										end else if (r_eff == 5'd31) begin
											if (b_eff < 4'(lpce_pkg::BLOCK_COUNT - 1)) begin
												pend_q  <= 1'b1;
												after_q <= lpce_pkg::F_IDLE;
											end else if (!pc_full) begin
												after_q <= lpce_pkg::F_MID;
											end else begin
												after_q <= lpce_pkg::F_GRP;
											end
										end else begin
											after_q <= lpce_pkg::F_IDLE;
										end
									end
								endcase
							end
						end
					end
					lpce_pkg::F_NEXT: begin
						nxt_q <= (az_q < cur_q) ? az_q + lpce_pkg::AZ_FULL : az_q;
					end
					lpce_pkg::F_MID: begin
						// hold a negative mid-block azimuth at zero
						cur_q <= mid_sum[AW] ? '0 : mid_sum[AW-1:0];
					end
					lpce_pkg::F_WRAP: begin
						if (cur_q > lpce_pkg::AZ_FULL) begin
							cur_q   <= wrap_az;
							prev_q  <= wrap_az[16:0];
							start_q <= wrap_az[16:0];
							pc_q    <= '0;
						end else begin
							prev_q <= cur_q[16:0];
						end
					end
					lpce_pkg::F_GRP: begin
						if (cfg.output_mode != lpce_pkg::MODE_NONE && !pc_full) begin
							pc_q <= grp_fits ? pc_q + PCW'(lpce_pkg::CHANNELS) : PCW'(MAX_POINTS);
						end
					end
					lpce_pkg::F_CUR: begin
						cur_q <= cur_adj;
					end
					lpce_pkg::F_CMP: begin
						if (cur_q[16:0] < prev_q) begin
							start_q <= cur_q[16:0];
							pc_q    <= '0;
						end
						prev_q <= cur_q[16:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// File: rtl/lpce_back.sv
// Word back end: takes commands from the queue and emits frame-end records
// and reordered group words through a registered output stage.
// Depends on lpce_pkg.
module lpce_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [63:0]      sensor_order,
	input  lpce_pkg::cmd_t   head,
	input  logic             empty,
	output logic             pop,
	input  logic             snap_load,
	input  lpce_pkg::group_t plain_grp,
	input  lpce_pkg::group_t packed_grp,
	output logic             snap_busy,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       kind,
	output logic [15:0]      word_value,
	output logic [16:0]      frame_start_azimuth,
	output logic [16:0]      frame_end_azimuth,
	output logic             last
);
	lpce_pkg::group_t plain_snap_q, packed_snap_q;
	lpce_pkg::cmd_t   cmd_q;
	logic             active_q;
	logic             phase_q;
	logic [3:0]       idx_q;
	logic             busy_q;
	logic             out_v_q;
	logic             adv;
	logic [3:0]       ch;
	logic             final_word;

	assign adv        = !out_v_q || !out_stall;
	assign pop        = adv && !active_q && !empty;
	assign ch         = sensor_order[{idx_q, 2'b00} +: 4];
	assign final_word = (idx_q == 4'd15) && (phase_q || !cmd_q.packed_en);
	assign snap_busy  = busy_q;
	assign out_valid  = out_v_q;

	always_ff @(posedge clk) begin
		if (snap_load) begin
			plain_snap_q  <= plain_grp;
			packed_snap_q <= packed_grp;
		end
		if (pop) begin
			cmd_q <= head;
		end
		if (adv) begin
			if (active_q) begin
				kind                <= phase_q ? lpce_pkg::KIND_PACKED : lpce_pkg::KIND_PLAIN;
				word_value          <= phase_q ? packed_snap_q[ch] : plain_snap_q[ch];
				frame_start_azimuth <= '0;
				frame_end_azimuth   <= '0;
				last                <= cmd_q.last && final_word;
			end else begin
				kind                <= lpce_pkg::KIND_FRAME_END;
				word_value          <= '0;
				frame_start_azimuth <= head.start_az;
				frame_end_azimuth   <= head.end_az;
				last                <= head.last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			phase_q  <= 1'b0;
			idx_q    <= '0;
			busy_q   <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (snap_load) begin
				busy_q <= 1'b1;
			end
			if (adv) begin
				if (active_q) begin
					out_v_q <= 1'b1;
					if (idx_q == 4'd15) begin
						idx_q <= '0;
						if (!phase_q && cmd_q.packed_en) begin
							phase_q <= 1'b1;
						end else begin
							active_q <= 1'b0;
							busy_q   <= 1'b0;
						end
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end else if (!empty) begin
					if (head.kind == lpce_pkg::CMD_GROUP) begin
						// open the group; words start next cycle
						out_v_q  <= 1'b0;
						active_q <= 1'b1;
						phase_q  <= !head.plain_en;
						idx_q    <= '0;
					end else begin
						out_v_q <= 1'b1;
					end
				end else begin
					out_v_q <= 1'b0;
				end
			end
		end
	end

endmodule

// File: rtl/lidar_packet_compact_encoder.sv
// Top level of the lidar packet compact encoder: configuration registers,
// packet front end, command queue and word back end.
// Depends on lpce_pkg, lpce_front, lpce_queue, lpce_back.
//
// channel   signals                                   moves
// input     in_valid / in_stall, data_byte, packet_start   one payload byte per word
// output    out_valid / out_stall, kind, word_value, ...   one result per word
// config    cfg_we, cfg_index, cfg_data                    one register write per cycle
//
// Most bytes are taken while the front end is idle; a return's last byte runs
// it through its divide and store steps, an azimuth byte through its azimuth
// steps, with in_stall high. A byte that yields commands holds the input until
// the last is flushed to the queue. The back end gives one word per cycle while
// out_stall is low, opens each group first, and gives 16 words per enabled kind.
// Reset clears all control state and configuration to its defaults.
// A stalled output fills the queue and then stalls the input.
module lidar_packet_compact_encoder #(
	parameter int MAX_POINTS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        packet_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [15:0] word_value,
	output logic [16:0] frame_start_azimuth,
	output logic [16:0] frame_end_azimuth,
	output logic        last
);
	lpce_pkg::front_cfg_t cfg_q;
	logic [63:0]          order_q;

	logic             q_push, q_pop, q_full, q_empty;
	lpce_pkg::cmd_t   q_in, q_head;
	logic             snap_load, snap_busy;
	lpce_pkg::group_t plain_grp, packed_grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_mode             <= lpce_pkg::MODE_PLAIN;
			cfg_q.centimetre_units        <= 1'b0;
			cfg_q.intensity_bits          <= 4'd4;
			cfg_q.intensity_low_placement <= 1'b0;
			order_q                       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lpce_pkg::REG_OUTPUT_MODE:  cfg_q.output_mode <= cfg_data[1:0];
				lpce_pkg::REG_CM_UNITS:     cfg_q.centimetre_units <= cfg_data[0];
				lpce_pkg::REG_INT_BITS:     cfg_q.intensity_bits <= cfg_data[3:0];
				lpce_pkg::REG_INT_LOW:      cfg_q.intensity_low_placement <= cfg_data[0];
				lpce_pkg::REG_SENSOR_ORDER: order_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lpce_front #(
		.MAX_POINTS(MAX_POINTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.packet_start (packet_start),
		.cfg          (cfg_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (q_in),
		.snap_busy    (snap_busy),
		.snap_load    (snap_load),
		.plain_grp    (plain_grp),
		.packed_grp   (packed_grp)
	);

	lpce_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	lpce_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.sensor_order        (order_q),
		.head                (q_head),
		.empty               (q_empty),
		.pop                 (q_pop),
		.snap_load           (snap_load),
		.plain_grp           (plain_grp),
		.packed_grp          (packed_grp),
		.snap_busy           (snap_busy),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.kind                (kind),
		.word_value          (word_value),
		.frame_start_azimuth (frame_start_azimuth),
		.frame_end_azimuth   (frame_end_azimuth),
		.last                (last)
	);

endmodule
